// ===== rtl/bir_pkg.sv =====
package bir_pkg;

    localparam int SRC_DIM_W   = 9;
    localparam int DST_DIM_W   = 13;
    localparam int STEP_W      = 25;
    localparam int POS_W       = 12;
    localparam int PIX_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int DST_LIMIT   = 4096;
    localparam int QUEUE_DEPTH = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd5;

    localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 9'd256;
    localparam logic [DST_DIM_W-1:0] DST_DIM_RESET = 13'd256;
    localparam logic [STEP_W-1:0]    STEP_RESET    = 25'd65536;

    typedef struct packed {
        logic             emit;
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } cmd_t;

endpackage

// ===== rtl/bilinear_image_resize_u8.sv =====
// Bilinear scaler for 8-bit grey images. A load word writes the next source pixel in
// raster order into a single-port image store of MAX_SRC_WIDTH*MAX_SRC_HEIGHT bytes; an
// emit word returns the next destination pixel in raster order, with frame_last set on
// the final pixel of the frame. Words enter a four-entry queue, so the input keeps
// flowing while earlier words are worked off. The back end writes each load to the
// store as it pops it; an emit passes through the source position, weights and row
// addresses, then the four neighbor reads through the single store port, and then the
// trailing blend and the hand-off to the output register. A finished pixel may wait in
// the output register while the next emit is already being computed. The
// store has no reset, so every pixel an emit reads must have been loaded first. Write the
// registers only while the block is idle.
module bilinear_image_resize_u8 #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [bir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [bir_pkg::PIX_W-1:0]        pixel_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bir_pkg::PIX_W-1:0]        pixel_out,
    output logic                             frame_last
);

    import bir_pkg::*;

    localparam int WW = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HW = $clog2(MAX_SRC_HEIGHT + 1);

    logic [SRC_DIM_W-1:0] src_width_reg;
    logic [SRC_DIM_W-1:0] src_height_reg;
    logic [DST_DIM_W-1:0] dst_width_reg;
    logic [DST_DIM_W-1:0] dst_height_reg;
    logic [STEP_W-1:0]    step_x_reg;
    logic [STEP_W-1:0]    step_y_reg;

    logic [WW-1:0]        w;
    logic [HW-1:0]        h;
    logic [DST_DIM_W-1:0] dw;
    logic [DST_DIM_W-1:0] dh;

    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    cmd_t                 push_cmd;
    cmd_t                 head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_DIM_RESET;
            src_height_reg <= SRC_DIM_RESET;
            dst_width_reg  <= DST_DIM_RESET;
            dst_height_reg <= DST_DIM_RESET;
            step_x_reg     <= STEP_RESET;
            step_y_reg     <= STEP_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_DIM_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_DIM_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_DIM_W-1:0];
                REG_STEP_X:     step_x_reg     <= cfg_data[STEP_W-1:0];
                REG_STEP_Y:     step_y_reg     <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sizes outside their legal ranges are clamped.
    always_comb
    begin
        if (src_width_reg == '0)
        begin
            w = WW'(1);
        end
        else if (int'(src_width_reg) > MAX_SRC_WIDTH)
        begin
            w = WW'(MAX_SRC_WIDTH);
        end
        else
        begin
            w = WW'(src_width_reg);
        end

        if (src_height_reg == '0)
        begin
            h = HW'(1);
        end
        else if (int'(src_height_reg) > MAX_SRC_HEIGHT)
        begin
            h = HW'(MAX_SRC_HEIGHT);
        end
        else
        begin
            h = HW'(src_height_reg);
        end

        if (dst_width_reg == '0)
        begin
            dw = DST_DIM_W'(1);
        end
        else if (int'(dst_width_reg) > DST_LIMIT)
        begin
            dw = DST_DIM_W'(DST_LIMIT);
        end
        else
        begin
            dw = dst_width_reg;
        end

        if (dst_height_reg == '0)
        begin
            dh = DST_DIM_W'(1);
        end
        else if (int'(dst_height_reg) > DST_LIMIT)
        begin
            dh = DST_DIM_W'(DST_LIMIT);
        end
        else
        begin
            dh = dst_height_reg;
        end
    end

    bir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .pixel_in  (pixel_in),
        .dw        (dw),
        .dh        (dh),
        .full      (full),
        .push      (push),
        .cmd       (push_cmd)
    );

    bir_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    bir_back #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .FRAC_BITS      (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .w          (w),
        .h          (h),
        .step_x     (step_x_reg),
        .step_y     (step_y_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

endmodule

// ===== rtl/bir_ram.sv =====
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bir_front.sv =====
module bir_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [bir_pkg::PIX_W-1:0]      pixel_in,
    input  logic [bir_pkg::DST_DIM_W-1:0]  dw,
    input  logic [bir_pkg::DST_DIM_W-1:0]  dh,
    input  logic                           full,
    output logic                           push,
    output bir_pkg::cmd_t                  cmd
);

    import bir_pkg::*;

    logic [POS_W-1:0]     col_reg;
    logic [POS_W-1:0]     row_reg;
    logic [POS_W-1:0]     col_next;
    logic [POS_W-1:0]     row_next;
    logic [DST_DIM_W-1:0] col_cur;
    logic [DST_DIM_W-1:0] row_cur;
    logic [DST_DIM_W-1:0] col_inc;
    logic [DST_DIM_W-1:0] row_inc;
    logic                 last;

    assign in_stall = full;
    assign push     = in_valid && !full;

    // The current position is normalized first, in case the frame size was reduced.
    always_comb
    begin
        col_cur = {1'b0, col_reg};
        row_cur = {1'b0, row_reg};
        if (col_cur >= dw)
        begin
            col_cur = '0;
            row_cur = row_cur + DST_DIM_W'(1);
        end
        if (row_cur >= dh)
        begin
            row_cur = '0;
        end
        last = (col_cur == dw - DST_DIM_W'(1)) && (row_cur == dh - DST_DIM_W'(1));

        col_inc = col_cur + DST_DIM_W'(1);
        row_inc = row_cur;
        if (col_inc >= dw)
        begin
            col_inc = '0;
            row_inc = row_cur + DST_DIM_W'(1);
            if (row_inc >= dh)
            begin
                row_inc = '0;
            end
        end

        col_next = col_reg;
        row_next = row_reg;
        if (push && (operation == OP_EMIT))
        begin
            col_next = col_inc[POS_W-1:0];
            row_next = row_inc[POS_W-1:0];
        end
    end

    always_comb
    begin
        cmd.emit  = (operation == OP_EMIT);
        cmd.pixel = pixel_in;
        cmd.col   = col_cur[POS_W-1:0];
        cmd.row   = row_cur[POS_W-1:0];
        cmd.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/bir_queue.sv =====
module bir_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bir_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bir_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    import bir_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/bir_back.sv =====
module bir_back #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bir_pkg::cmd_t                           head,
    input  logic                                    empty,
    output logic                                    pop,
    input  logic [$clog2(MAX_SRC_WIDTH + 1)-1:0]    w,
    input  logic [$clog2(MAX_SRC_HEIGHT + 1)-1:0]   h,
    input  logic [bir_pkg::STEP_W-1:0]              step_x,
    input  logic [bir_pkg::STEP_W-1:0]              step_y,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [bir_pkg::PIX_W-1:0]               pixel_out,
    output logic                                    frame_last
);

    import bir_pkg::*;

    localparam int WW   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HW   = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int XW   = $clog2(MAX_SRC_WIDTH);
    localparam int YW   = $clog2(MAX_SRC_HEIGHT);
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW   = $clog2(DEPTH);
    localparam int TOTW = AW + 1;
    localparam int PXW  = POS_W + STEP_W;
    localparam int IPW  = PXW - FRAC_BITS;
    localparam int WGW  = FRAC_BITS + 1;
    localparam int TW   = PIX_W + FRAC_BITS;
    localparam int VW   = PIX_W + 2 * FRAC_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FRAC = 4'd1;
    localparam logic [3:0] ST_BASE = 4'd2;
    localparam logic [3:0] ST_RD0  = 4'd3;
    localparam logic [3:0] ST_RD1  = 4'd4;
    localparam logic [3:0] ST_RD2  = 4'd5;
    localparam logic [3:0] ST_RD3  = 4'd6;
    localparam logic [3:0] ST_MAC  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam logic [WGW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [AW-1:0]    load_addr_reg;
    logic [AW-1:0]    load_addr_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_load;

    logic [PXW-1:0]   px_reg;
    logic [PXW-1:0]   py_reg;
    logic             last_reg;
    logic [XW-1:0]    ix_reg;
    logic [XW-1:0]    ix1_reg;
    logic [YW-1:0]    iy_reg;
    logic [WGW-1:0]   wx0_reg;
    logic [WGW-1:0]   wx1_reg;
    logic [WGW-1:0]   wy0_reg;
    logic [WGW-1:0]   wy1_reg;
    logic [AW-1:0]    base0_reg;
    logic [AW-1:0]    base1_reg;
    logic [TW-1:0]    top_reg;
    logic [TW-1:0]    bot_reg;
    logic [VW-1:0]    vacc_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             frame_last_reg;

    logic [WW-1:0]    wm1;
    logic [HW-1:0]    hm1;
    logic [TOTW-1:0]  total;
    logic [AW-1:0]    load_wr;
    logic [TOTW-1:0]  load_inc;
    logic [IPW-1:0]   ix_raw;
    logic [IPW-1:0]   iy_raw;
    logic             blend_x;
    logic             blend_y;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [AW-1:0]    base0;
    logic [VW-1:0]    blend_sum;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [PIX_W-1:0] ram_rdata;

    assign wm1   = w - WW'(1);
    assign hm1   = h - HW'(1);
    assign total = TOTW'(w) * TOTW'(h);

    // Loads wrap to the first entry once the image is full or after a size change.
    assign load_wr  = ({1'b0, load_addr_reg} < total) ? load_addr_reg : '0;
    assign load_inc = {1'b0, load_wr} + TOTW'(1);

    assign ix_raw  = px_reg[PXW-1:FRAC_BITS];
    assign iy_raw  = py_reg[PXW-1:FRAC_BITS];
    assign blend_x = ({1'b0, px_reg} + (PXW + 1)'(step_x))
                     <= ((PXW + 1)'(wm1) << FRAC_BITS);
    assign blend_y = ({1'b0, py_reg} + (PXW + 1)'(step_y))
                     <= ((PXW + 1)'(hm1) << FRAC_BITS);
    assign fx      = blend_x ? px_reg[FRAC_BITS-1:0] : '0;
    assign fy      = blend_y ? py_reg[FRAC_BITS-1:0] : '0;

    assign base0     = AW'(iy_reg) * AW'(w);
    assign blend_sum = vacc_reg + VW'(bot_reg) * VW'(wy1_reg);

    bir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.pixel),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        load_addr_next = load_addr_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = base0_reg + AW'(ix_reg);
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.emit)
                    begin
                        state_next = ST_FRAC;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ram_addr       = load_wr;
                        load_addr_next = (load_inc >= total) ? '0 : load_inc[AW-1:0];
                    end
                end
            end
            ST_FRAC:
            begin
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                ram_addr   = base0_reg + AW'(ix_reg);
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                ram_addr   = base0_reg + AW'(ix1_reg);
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                ram_addr   = base1_reg + AW'(ix_reg);
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                ram_addr   = base1_reg + AW'(ix1_reg);
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Each read returns in the cycle after its address, so the blend trails the reads.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                px_reg   <= PXW'(head.col) * PXW'(step_x);
                py_reg   <= PXW'(head.row) * PXW'(step_y);
                last_reg <= head.last;
            end
            ST_FRAC:
            begin
                ix_reg  <= (ix_raw > IPW'(wm1)) ? XW'(wm1) : XW'(ix_raw);
                iy_reg  <= (iy_raw > IPW'(hm1)) ? YW'(hm1) : YW'(iy_raw);
                wx0_reg <= ONE - {1'b0, fx};
                wx1_reg <= {1'b0, fx};
                wy0_reg <= ONE - {1'b0, fy};
                wy1_reg <= {1'b0, fy};
            end
            ST_BASE:
            begin
                base0_reg <= base0;
                base1_reg <= base0 + ((iy_reg == YW'(hm1)) ? '0 : AW'(w));
                ix1_reg   <= (ix_reg == XW'(wm1)) ? ix_reg : ix_reg + XW'(1);
            end
            ST_RD1:
            begin
                top_reg <= TW'(ram_rdata) * TW'(wx0_reg);
            end
            ST_RD2:
            begin
                top_reg <= top_reg + TW'(ram_rdata) * TW'(wx1_reg);
            end
            ST_RD3:
            begin
                bot_reg  <= TW'(ram_rdata) * TW'(wx0_reg);
                vacc_reg <= VW'(top_reg) * VW'(wy0_reg);
            end
            ST_MAC:
            begin
                bot_reg <= bot_reg + TW'(ram_rdata) * TW'(wx1_reg);
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            pixel_out_reg  <= blend_sum[VW-1:2*FRAC_BITS];
            frame_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            load_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_addr_reg <= load_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

endmodule
